>>> hw/rtl/lsf_pkg.sv
package lsf_pkg;

    // Switch geometry.
    localparam int NUM_PORTS       = 4;
    localparam int QUEUE_BYTES_MAX = 2048;
    localparam int PORT_IDX_W      = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    // Field widths fixed by the request and result formats.
    localparam int PORT_W   = 2;
    localparam int ID_W     = 32;
    localparam int PLEN_W   = 32;
    localparam int RLEN_W   = 16;
    localparam int TIME_W   = 48;
    localparam int STATUS_W = 3;
    localparam int MASK_W   = 4;

    // Configuration register widths, indexes and reset values.
    localparam int LIFE_W  = 32;
    localparam int MFB_W   = 12;
    localparam int QCAP_W  = 12;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_LIFETIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY  = 2'd2;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(10 * 1000000);
    localparam logic [MFB_W-1:0]  MFB_RESET      = MFB_W'(128);
    localparam logic [QCAP_W-1:0] QCAP_RESET     = QCAP_W'(2048);

    // Header bytes added to every queued frame.
    localparam logic [MFB_W-1:0] HDR_BYTES = MFB_W'(16);

    // Queue fill counters only ever reach the smaller of the two capacity limits.
    localparam int QCAP_REG_MAX = (1 << QCAP_W) - 1;
    localparam int CAP_MAX = (QUEUE_BYTES_MAX < QCAP_REG_MAX) ? QUEUE_BYTES_MAX : QCAP_REG_MAX;
    localparam int FILL_W  = $clog2(CAP_MAX + 1);
    localparam int SUM_W   = ((FILL_W > MFB_W) ? FILL_W : MFB_W) + 1;

    typedef enum logic [1:0] {
        FUNC_WRITE      = 2'd0,
        FUNC_CONNECT    = 2'd1,
        FUNC_DISCONNECT = 2'd2,
        FUNC_READ       = 2'd3
    } lsf_func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_WRITE_LEN = 3'd1,
        STAT_PAYLOAD   = 3'd2,
        STAT_BUSY      = 3'd3,
        STAT_SHORT     = 3'd4
    } lsf_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_PUSH,
        ST_DONE
    } lsf_state_t;

    typedef struct packed {
        lsf_func_t           func;
        logic [PORT_W-1:0]   port;
        logic [ID_W-1:0]     src_id;
        logic [ID_W-1:0]     dst_id;
        logic [PLEN_W-1:0]   payload_length;
        logic [RLEN_W-1:0]   request_length;
        logic [TIME_W-1:0]   now;
    } lsf_in_t;

    typedef struct packed {
        lsf_status_t         status;
        logic [MASK_W-1:0]   delivered_mask;
        logic [MASK_W-1:0]   dropped_mask;
        logic                broadcast;
    } lsf_out_t;

endpackage

>>> hw/rtl/learning_switch_forwarder.sv
// Forwarding engine of a small learning switch. Each port holds a connected
// flag, one learned host identifier with an expiry time, and the byte count
// of its output queue. A request word is a frame write, a connect, a
// disconnect or a read drain; every request returns exactly one result word.
// A frame write learns the sender on its ingress port, checks the write and
// payload lengths, then looks for the first other connected port, in
// ascending order, whose learned identifier matches the destination and has
// not expired. It goes to that port alone, or is flooded to every other
// connected port when there is none; a queue without room drops it whole.
// The engine handles one request at a time under a small sequencer: it
// accepts the word, checks and learns (or finishes a connect, disconnect
// or read), examines the ports one at a time with the single shared
// identifier and expiry comparator, updates the queues one at a time
// through the single shared fill adder, and hands the result to the output
// register, waiting while that register still holds an unread result.
// The input stays ready only while the sequencer is idle and out of reset,
// but a finished result can sit in the output register while the next
// request is taken. The reset is synchronous, active low.
// Configuration registers are written via cfg_wr_en, cfg_index and cfg_wdata;
// the user must write them only while the engine is idle, which the block
// does not enforce. Index 0 is the cache lifetime in ticks, 1 the largest
// frame write and 2 the per-port queue capacity, in bytes; others are ignored.
module learning_switch_forwarder (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [lsf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lsf_pkg::CFG_W-1:0]     cfg_wdata,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  lsf_pkg::lsf_in_t              s_data,

    output logic                          m_valid,
    input  logic                          m_ready,
    output lsf_pkg::lsf_out_t             m_data
);
    import lsf_pkg::*;

    localparam logic [PORT_IDX_W-1:0] LAST_IDX = PORT_IDX_W'(NUM_PORTS - 1);

    // Configuration registers.
    logic [LIFE_W-1:0] lifetime_reg;
    logic [MFB_W-1:0]  mfb_reg;
    logic [QCAP_W-1:0] qcap_reg;

    // Per-port state.
    logic              conn_reg   [NUM_PORTS];
    logic              conn_next  [NUM_PORTS];
    logic [ID_W-1:0]   host_reg   [NUM_PORTS];
    logic [ID_W-1:0]   host_next  [NUM_PORTS];
    logic [TIME_W-1:0] expiry_reg [NUM_PORTS];
    logic [TIME_W-1:0] expiry_next[NUM_PORTS];
    logic [FILL_W-1:0] fill_reg   [NUM_PORTS];
    logic [FILL_W-1:0] fill_next  [NUM_PORTS];

    // Sequencer and working registers.
    lsf_state_t        state_reg, state_next;
    logic [PORT_IDX_W-1:0] idx_reg, idx_next;
    lsf_in_t           req_reg;
    logic [MFB_W-1:0]  size_reg, size_next;
    logic              found_reg, found_next;
    lsf_status_t       status_reg, status_next;
    logic [MASK_W-1:0] dmask_reg, dmask_next;
    logic [MASK_W-1:0] xmask_reg, xmask_next;
    logic              bcast_reg, bcast_next;

    // Output register.
    logic              m_valid_reg, m_valid_next;
    lsf_out_t          m_data_reg, m_data_next;

    // Combinational helpers.
    logic [PORT_IDX_W-1:0] port_idx;
    logic                  port_ok;
    logic [MFB_W-1:0]      limit;
    logic [FILL_W-1:0]     cap;
    logic                  scan_hit;
    logic                  push_target;
    logic [SUM_W-1:0]      push_sum;
    logic                  push_fits;

    // Maps a port number to its bit in the 4-bit result masks; ports beyond
    // the mask width are served but not reported.
    function automatic logic [MASK_W-1:0] port_bit(input logic [PORT_IDX_W-1:0] p);
        logic [MASK_W-1:0] m;
        m = '0;
        for (int b = 0; b < MASK_W; b++) begin
            if (int'(p) == b) begin
                m[b] = 1'b1;
            end
        end
        return m;
    endfunction

    assign port_idx = PORT_IDX_W'(req_reg.port);
    assign port_ok  = int'(req_reg.port) < NUM_PORTS;
    assign limit    = (mfb_reg > HDR_BYTES) ? (mfb_reg - HDR_BYTES) : '0;

    // Effective capacity is the register clipped to the queue size.
    assign cap = (int'(qcap_reg) > CAP_MAX) ? FILL_W'(CAP_MAX) : FILL_W'(qcap_reg);

    // Shared comparator: does the port under the scan index hold a live
    // entry for the destination?
    assign scan_hit = (idx_reg != port_idx) && conn_reg[idx_reg]
                   && (host_reg[idx_reg] == req_reg.dst_id)
                   && (req_reg.now < expiry_reg[idx_reg]);

    // Shared fill adder: room check for the queue under the scan index.
    assign push_sum    = SUM_W'(fill_reg[idx_reg]) + SUM_W'(size_reg);
    assign push_fits   = push_sum <= SUM_W'(cap);
    assign push_target = found_reg || ((idx_reg != port_idx) && conn_reg[idx_reg]);

    assign s_ready = (state_reg == ST_IDLE) && aresetn;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        size_next    = size_reg;
        found_next   = found_reg;
        status_next  = status_reg;
        dmask_next   = dmask_reg;
        xmask_next   = xmask_reg;
        bcast_next   = bcast_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        conn_next    = conn_reg;
        host_next    = host_reg;
        expiry_next  = expiry_reg;
        fill_next    = fill_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next  = ST_EXEC;
                    idx_next    = '0;
                    found_next  = 1'b0;
                    status_next = STAT_OK;
                    dmask_next  = '0;
                    xmask_next  = '0;
                    bcast_next  = 1'b0;
                end
            end

            ST_EXEC: begin
                state_next = ST_DONE;
                size_next  = MFB_W'(req_reg.payload_length) + HDR_BYTES;
                if (port_ok) begin
                    unique case (req_reg.func)
                        FUNC_WRITE: begin
                            if (req_reg.request_length > RLEN_W'(mfb_reg)) begin
                                status_next = STAT_WRITE_LEN;
                            end else begin
                                host_next[port_idx]   = req_reg.src_id;
                                expiry_next[port_idx] = req_reg.now + TIME_W'(lifetime_reg);
                                if (req_reg.payload_length > PLEN_W'(limit)) begin
                                    status_next = STAT_PAYLOAD;
                                end else begin
                                    state_next = ST_SCAN;
                                end
                            end
                        end
                        FUNC_CONNECT: begin
                            if (conn_reg[port_idx]) begin
                                status_next = STAT_BUSY;
                            end else begin
                                conn_next[port_idx]   = 1'b1;
                                expiry_next[port_idx] = '0;
                            end
                        end
                        FUNC_DISCONNECT: begin
                            conn_next[port_idx] = 1'b0;
                        end
                        FUNC_READ: begin
                            if (RLEN_W'(fill_reg[port_idx]) < req_reg.request_length) begin
                                status_next = STAT_SHORT;
                            end else begin
                                fill_next[port_idx] = fill_reg[port_idx]
                                                    - FILL_W'(req_reg.request_length);
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                if (scan_hit) begin
                    found_next = 1'b1;
                    state_next = ST_PUSH;
                end else if (idx_reg == LAST_IDX) begin
                    bcast_next = 1'b1;
                    idx_next   = '0;
                    state_next = ST_PUSH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_PUSH: begin
                if (push_target) begin
                    if (push_fits) begin
                        fill_next[idx_reg] = FILL_W'(push_sum);
                        dmask_next = dmask_reg | port_bit(idx_reg);
                    end else begin
                        xmask_next = xmask_reg | port_bit(idx_reg);
                    end
                end
                if (found_reg || idx_reg == LAST_IDX) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.status         = status_reg;
                    m_data_next.delivered_mask = dmask_reg;
                    m_data_next.dropped_mask   = xmask_reg;
                    m_data_next.broadcast      = bcast_reg;
                    state_next                 = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and per-port tables.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            lifetime_reg <= LIFETIME_RESET;
            mfb_reg      <= MFB_RESET;
            qcap_reg     <= QCAP_RESET;
            for (int p = 0; p < NUM_PORTS; p++) begin
                conn_reg[p]   <= 1'b0;
                host_reg[p]   <= '0;
                expiry_reg[p] <= '0;
                fill_reg[p]   <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            conn_reg    <= conn_next;
            host_reg    <= host_next;
            expiry_reg  <= expiry_next;
            fill_reg    <= fill_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_CACHE_LIFETIME:  lifetime_reg <= LIFE_W'(cfg_wdata);
                    CFG_MAX_FRAME_BYTES: mfb_reg      <= MFB_W'(cfg_wdata);
                    CFG_QUEUE_CAPACITY:  qcap_reg     <= QCAP_W'(cfg_wdata);
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working payload registers.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        idx_reg    <= idx_next;
        size_reg   <= size_next;
        found_reg  <= found_next;
        status_reg <= status_next;
        dmask_reg  <= dmask_next;
        xmask_reg  <= xmask_next;
        bcast_reg  <= bcast_next;
        m_data_reg <= m_data_next;
    end

    // A frame never lands in and is dropped from the same queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.delivered_mask & m_data.dropped_mask) == '0)
        else $error("port both delivered and dropped");

    // A forwarded (not flooded) frame targets one port at most.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.broadcast |-> $onehot0(m_data.delivered_mask | m_data.dropped_mask))
        else $error("unicast frame reached several ports");

    // Any failure status comes with empty masks and no flood.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != STAT_OK |->
            m_data.delivered_mask == '0 && m_data.dropped_mask == '0 && !m_data.broadcast)
        else $error("failed request reports forwarding");

    // Requests other than frame writes never forward.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && req_reg.func != FUNC_WRITE |->
            dmask_reg == '0 && xmask_reg == '0 && !bcast_reg)
        else $error("non-frame request forwarded");

    // An accepted request always starts with the check step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == ST_EXEC)
        else $error("accepted word not executed");

endmodule

>>> tb/learning_switch_forwarder_tb.sv
module learning_switch_forwarder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsf_pkg::*;

    // The slowest request is a flooded frame, which scans and then visits every
    // port, so a little more than its run is enough for the engine to settle
    // once the last result word has come out.
    localparam int DRAIN_CYCLES = 2 * NUM_PORTS + 8;
    localparam int LONG_HOLD    = 400;
    localparam int HOSTS        = 6;
    localparam int MAX_PRINTS   = 100;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    lsf_in_t     s_data;
    logic        m_valid;
    logic        m_ready;
    lsf_out_t    m_data;

    learning_switch_forwarder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // Request words waiting to be offered, and the result words that the
    // accepted requests must produce, oldest first.
    lsf_in_t  send_q[$];
    lsf_out_t awaited_results[$];

    int unsigned fail_count = 0;
    int unsigned result_count = 0;
    bit          word_taken = 1'b0;
    bit          idle_enable = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;

    // Timestamp that advances from word to word, and a small pool of host
    // identifiers so that destinations often match a learned sender.
    logic [TIME_W-1:0] tick;
    logic [ID_W-1:0]   host_pool[HOSTS];

    // Our own copy of the configuration registers.
    logic [LIFE_W-1:0] cfg_lifetime  = LIFETIME_RESET;
    logic [MFB_W-1:0]  cfg_max_frame = MFB_RESET;
    logic [QCAP_W-1:0] cfg_queue_cap = QCAP_RESET;

    // Our own copy of the per-port switch state, all zero after reset.
    bit                link_up[NUM_PORTS]      = '{default: 1'b0};
    logic [ID_W-1:0]   host_tag[NUM_PORTS]     = '{default: '0};
    logic [TIME_W-1:0] tag_expiry[NUM_PORTS]   = '{default: '0};
    int unsigned       queued_bytes[NUM_PORTS] = '{default: 0};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (fail_count < MAX_PRINTS) begin
            $display("[%0t] result %0d: %s is %0d, expected %0d",
                     $realtime, result_count, what, got, want);
        end
        fail_count++;
    endtask

    // Pushes a frame into a port queue if it fits whole. The usable capacity
    // is the register value clamped to what the hardware queues can hold.
    function automatic bit queue_push(int i, int unsigned size_b);
        int unsigned cap;
        cap = (cfg_queue_cap > QUEUE_BYTES_MAX) ? QUEUE_BYTES_MAX : cfg_queue_cap;
        if (queued_bytes[i] + size_b > cap) begin
            return 1'b0;
        end
        queued_bytes[i] += size_b;
        return 1'b1;
    endfunction

    // Computes the result word of one request and advances our switch state.
    function automatic lsf_out_t forward_result(lsf_in_t w);
        lsf_out_t    r;
        int unsigned limit;
        int unsigned size_b;
        int          p;
        bit          hit;
        r = '0;
        r.status = STAT_OK;
        p = w.port;
        limit = (cfg_max_frame > HDR_BYTES) ? cfg_max_frame - HDR_BYTES : 0;
        case (w.func)
            FUNC_WRITE: begin
                if (w.request_length > cfg_max_frame) begin
                    r.status = STAT_WRITE_LEN;
                end else begin
                    // The sender is learned even when the payload is rejected.
                    host_tag[p] = w.src_id;
                    tag_expiry[p] = w.now + TIME_W'(cfg_lifetime);
                    if (w.payload_length > limit) begin
                        r.status = STAT_PAYLOAD;
                    end else begin
                        size_b = w.payload_length + HDR_BYTES;
                        hit = 1'b0;
                        for (int i = 0; i < NUM_PORTS; i++) begin
                            if (!hit && i != p && link_up[i] && host_tag[i] == w.dst_id &&
                                w.now < tag_expiry[i]) begin
                                hit = 1'b1;
                                if (queue_push(i, size_b)) r.delivered_mask[i] = 1'b1;
                                else r.dropped_mask[i] = 1'b1;
                            end
                        end
                        if (!hit) begin
                            r.broadcast = 1'b1;
                            for (int i = 0; i < NUM_PORTS; i++) begin
                                if (i != p && link_up[i]) begin
                                    if (queue_push(i, size_b)) r.delivered_mask[i] = 1'b1;
                                    else r.dropped_mask[i] = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            FUNC_CONNECT: begin
                if (link_up[p]) begin
                    r.status = STAT_BUSY;
                end else begin
                    // A fresh connect forgets the old entry but keeps the queue.
                    link_up[p] = 1'b1;
                    tag_expiry[p] = '0;
                end
            end
            FUNC_DISCONNECT: begin
                link_up[p] = 1'b0;
            end
            default: begin
                if (queued_bytes[p] < w.request_length) r.status = STAT_SHORT;
                else queued_bytes[p] -= w.request_length;
            end
        endcase
        return r;
    endfunction

    // Input side: sampled at the rising edge. An accepted request word is
    // predicted right away, so the expected results stay in request order.
    // Output side: every accepted result word is checked against the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        lsf_out_t want;
        word_taken = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                word_taken = 1'b1;
                awaited_results.push_back(forward_result(s_data));
            end
            if (m_valid && m_ready) begin
                result_count++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result word, count", result_count, 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.delivered_mask !== want.delivered_mask)
                        report_mismatch("delivered_mask", m_data.delivered_mask,
                                        want.delivered_mask);
                    if (m_data.dropped_mask !== want.dropped_mask)
                        report_mismatch("dropped_mask", m_data.dropped_mask,
                                        want.dropped_mask);
                    if (m_data.broadcast !== want.broadcast)
                        report_mismatch("broadcast", m_data.broadcast, want.broadcast);
                end
            end
        end
    end

    // Request driver. It changes the channel only at the falling edge and only
    // once the current word has been taken, so valid and the payload hold
    // steady while the engine is busy. After a word it sometimes pauses for a
    // random burst of cycles.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || word_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (send_q.size() > 0) begin
                s_data <= send_q.pop_front();
                s_valid <= 1'b1;
                if (idle_enable && $urandom_range(0, 4) == 0) send_gap = $urandom_range(1, 13);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver. It stalls in random bursts, and on request it holds
    // off for a long stretch, counting the cycles itself, so that the engine
    // backs up and stops taking requests.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (idle_enable && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 13);
        end
    end

    // Waits until every queued request has been taken and every expected
    // result word has arrived. Checked just after the rising edge so that the
    // clocked processes of that edge have already run.
    task automatic wait_idle();
        do begin
            @(posedge aclk);
            #1;
        end while (send_q.size() != 0 || s_valid || awaited_results.size() != 0);
    endtask

    task automatic settle();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Writes one register; our copy changes with it, which is safe because
    // the engine is idle whenever this runs.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_CACHE_LIFETIME:  cfg_lifetime = val[LIFE_W-1:0];
            CFG_MAX_FRAME_BYTES: cfg_max_frame = val[MFB_W-1:0];
            CFG_QUEUE_CAPACITY:  cfg_queue_cap = val[QCAP_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_W-1:0] life, int unsigned mfb, int unsigned qcap);
        settle();
        write_reg(CFG_CACHE_LIFETIME, life);
        write_reg(CFG_MAX_FRAME_BYTES, CFG_W'(mfb));
        write_reg(CFG_QUEUE_CAPACITY, CFG_W'(qcap));
    endtask

    function automatic lsf_in_t make_request(lsf_func_t f, int unsigned p, logic [ID_W-1:0] src,
                                             logic [ID_W-1:0] dst, logic [PLEN_W-1:0] plen,
                                             logic [RLEN_W-1:0] rlen, logic [TIME_W-1:0] t);
        lsf_in_t w;
        w.func = f;
        w.port = PORT_W'(p);
        w.src_id = src;
        w.dst_id = dst;
        w.payload_length = plen;
        w.request_length = rlen;
        w.now = t;
        return w;
    endfunction

    // Mostly well-formed traffic: frame writes within the configured limits,
    // between known hosts, with a rising timestamp; a few words carry wild
    // lengths, identifiers or timestamps.
    function automatic lsf_in_t random_word(int unsigned tick_step);
        lsf_in_t     w;
        int unsigned pick;
        int unsigned limit;
        limit = (cfg_max_frame > HDR_BYTES) ? cfg_max_frame - HDR_BYTES : 0;
        tick += $urandom_range(0, tick_step);
        w.now = ($urandom_range(0, 49) == 0) ? {16'($urandom), 32'($urandom)} : tick;
        w.port = PORT_W'($urandom_range(0, NUM_PORTS - 1));
        w.src_id = ($urandom_range(0, 19) == 0) ? $urandom : host_pool[$urandom_range(0, HOSTS - 1)];
        w.dst_id = ($urandom_range(0, 19) == 0) ? $urandom : host_pool[$urandom_range(0, HOSTS - 1)];
        w.payload_length = $urandom;
        w.request_length = 16'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 64) begin
            w.func = FUNC_WRITE;
            if ($urandom_range(0, 19) != 0)
                w.request_length = 16'($urandom_range(0, cfg_max_frame));
            if ($urandom_range(0, 19) != 0)
                w.payload_length = ($urandom_range(0, 3) == 0) ? $urandom_range(0, limit)
                                                               : $urandom_range(0, limit / 8);
        end else if (pick < 72) begin
            w.func = FUNC_CONNECT;
        end else if (pick < 77) begin
            w.func = FUNC_DISCONNECT;
        end else begin
            w.func = FUNC_READ;
            if ($urandom_range(0, 29) != 0)
                w.request_length = 16'(HDR_BYTES * $urandom_range(0, 6));
        end
        return w;
    endfunction

    // One block of random traffic. With a hold the receiver stops for a long
    // stretch while all words are already queued; with a pause the sender
    // stops halfway until every result word has come back.
    task automatic run_phase(int n, int unsigned tick_step, bit with_hold, bit with_pause);
        int half;
        half = with_pause ? n / 2 : n;
        tick = {16'($urandom), 32'($urandom)};
        for (int k = 0; k < half; k++) send_q.push_back(random_word(tick_step));
        if (with_hold) hold_request = 1'b1;
        if (with_pause) begin
            wait_idle();
            for (int k = half; k < n; k++) send_q.push_back(random_word(tick_step));
        end
        wait_idle();
    endtask

    initial begin
        logic [TIME_W-1:0] t0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        for (int h = 0; h < HOSTS; h++) host_pool[h] = $urandom;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset configuration: a 128-byte write
        // limit, so the payload limit is 112, and a lifetime of ten million.
        t0 = 48'd1000;
        // No port is connected yet, so the frame floods to nobody.
        send_q.push_back(make_request(FUNC_WRITE, 0, host_pool[0], host_pool[1], 0, 16, t0));
        for (int p = 0; p < NUM_PORTS; p++)
            send_q.push_back(make_request(FUNC_CONNECT, p, 0, 0, 0, 0, t0));
        // Connecting a connected port is refused.
        send_q.push_back(make_request(FUNC_CONNECT, 2, 0, 0, 0, 0, t0));
        // Largest legal write and payload, unknown destination: flooded.
        send_q.push_back(make_request(FUNC_WRITE, 0, host_pool[0], host_pool[5], 112, 128, t0));
        // Destination learned on port 0: sent there alone.
        send_q.push_back(make_request(FUNC_WRITE, 1, host_pool[1], host_pool[0], 0, 0, t0 + 1));
        // Write one byte too long, then payload one byte too long.
        send_q.push_back(make_request(FUNC_WRITE, 2, host_pool[2], host_pool[0], 0, 129, t0 + 2));
        send_q.push_back(make_request(FUNC_WRITE, 2, host_pool[2], host_pool[1], 113, 128, t0 + 3));
        // The rejected payload still taught port 2 its sender.
        send_q.push_back(make_request(FUNC_WRITE, 3, host_pool[3], host_pool[2], 10, 50, t0 + 4));
        send_q.push_back(make_request(FUNC_WRITE, 3, '1, '0, '1, '1, t0 + 5));
        send_q.push_back(make_request(FUNC_WRITE, 3, '0, '1, '1, 100, t0 + 6));
        // Reads: too many bytes, zero bytes, and a part of what is queued.
        send_q.push_back(make_request(FUNC_READ, 0, 0, 0, 0, '1, t0 + 7));
        send_q.push_back(make_request(FUNC_READ, 0, 0, 0, 0, 0, t0 + 7));
        send_q.push_back(make_request(FUNC_READ, 1, 0, 0, 0, 16, t0 + 7));
        // Disconnecting twice is fine both times.
        send_q.push_back(make_request(FUNC_DISCONNECT, 3, 0, 0, 0, 0, t0 + 8));
        send_q.push_back(make_request(FUNC_DISCONNECT, 3, 0, 0, 0, 0, t0 + 8));
        // An entry is valid up to one tick before its expiry, not at it.
        t0 = 48'd50_000_000;
        send_q.push_back(make_request(FUNC_WRITE, 1, host_pool[4], host_pool[3], 0, 16, t0));
        send_q.push_back(make_request(FUNC_WRITE, 0, host_pool[0], host_pool[4], 0, 16,
                                      t0 + LIFETIME_RESET - 1));
        send_q.push_back(make_request(FUNC_WRITE, 0, host_pool[0], host_pool[4], 0, 16,
                                      t0 + LIFETIME_RESET));
        // Learning at the very top of the timestamp range wraps the expiry
        // around, so the entry is already stale.
        send_q.push_back(make_request(FUNC_WRITE, 2, host_pool[5], host_pool[3], 0, 16, '1));
        send_q.push_back(make_request(FUNC_WRITE, 0, host_pool[0], host_pool[5], 0, 16, '1));
        // Reconnecting port 3 gives it an empty entry again.
        send_q.push_back(make_request(FUNC_CONNECT, 3, 0, 0, 0, 0, t0));
        send_q.push_back(make_request(FUNC_WRITE, 1, host_pool[1], host_pool[3], 0, 16, t0));
        wait_idle();

        // Smallest limits: only empty payloads fit, and one frame fills a
        // queue. A zero lifetime means nothing is ever matched.
        set_config('0, 16, 16);
        run_phase(240, 3, 1'b0, 1'b0);

        // Largest limits and a lifetime that never runs out in practice; the
        // receiver holds off for a long stretch.
        set_config('1, 2048, 2048);
        run_phase(240, 1 << 20, 1'b1, 1'b0);

        // Short lifetime against a rising clock, so entries age out.
        set_config(60, 200, 300);
        run_phase(240, 8, 1'b0, 1'b1);

        set_config($urandom_range(1, 500), $urandom_range(16, 2048), $urandom_range(16, 2048));
        run_phase(240, 20, 1'b0, 1'b0);

        set_config(30, 64, 100);
        run_phase(240, 4, 1'b1, 1'b0);

        set_config($urandom, $urandom_range(16, 2048), $urandom_range(16, 2048));
        run_phase(240, 1 << 16, 1'b0, 1'b1);

        // Last stretch at full rate on both sides.
        set_config(1000, 128, 512);
        idle_enable = 1'b0;
        run_phase(240, 50, 1'b0, 1'b0);

        settle();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
